### hdl/lwcb_pkg.sv
package lwcb_pkg;

    // Pixel component and offset widths
    localparam int PIX_W  = 8;
    localparam int OFS_W  = 9;
    localparam int IDX_W  = 3;
    localparam int NUM_CFG = 6;

    // Register indexes
    localparam logic [IDX_W-1:0] CFG_SHADOW_RED      = 3'd0;
    localparam logic [IDX_W-1:0] CFG_SHADOW_GREEN    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_SHADOW_BLUE     = 3'd2;
    localparam logic [IDX_W-1:0] CFG_HIGHLIGHT_RED   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_HIGHLIGHT_GREEN = 3'd4;
    localparam logic [IDX_W-1:0] CFG_HIGHLIGHT_BLUE  = 3'd5;

    // Fixed-point luma weights (sum 256)
    localparam logic [7:0] LUMA_WR = 8'd77;
    localparam logic [7:0] LUMA_WG = 8'd150;
    localparam logic [7:0] LUMA_WB = 8'd29;
    localparam logic [7:0] LUMA_RND = 8'd128;

    // Number of register stages from accept to result
    localparam int PIPE_DEPTH = 4;

    typedef logic [PIX_W-1:0]        pix_t;
    typedef logic signed [OFS_W-1:0] ofs_t;

    // Stage enable handed to each datapath block
    typedef struct packed {
        logic advance;
    } stage_ctl_t;

endpackage

### hdl/lwcb_luma.sv
// Stage 1: fixed-point luma, pixel carried alongside.
module lwcb_luma
(
    input  logic                 clk,
    input  lwcb_pkg::stage_ctl_t ctl,
    input  lwcb_pkg::pix_t       red,
    input  lwcb_pkg::pix_t       green,
    input  lwcb_pkg::pix_t       blue,
    output lwcb_pkg::pix_t       luma,
    output lwcb_pkg::pix_t       red_q,
    output lwcb_pkg::pix_t       green_q,
    output lwcb_pkg::pix_t       blue_q
);

    logic [15:0]    sum;
    lwcb_pkg::pix_t luma_reg, luma_next;
    lwcb_pkg::pix_t red_reg, green_reg, blue_reg;

    // max 256*255+128 fits 16 bits
    assign sum = 16'(red) * 16'(lwcb_pkg::LUMA_WR) + 16'(green) * 16'(lwcb_pkg::LUMA_WG)
               + 16'(blue) * 16'(lwcb_pkg::LUMA_WB) + 16'(lwcb_pkg::LUMA_RND);
    assign luma_next = sum[15:8];

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            luma_reg  <= luma_next;
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
        end
    end

    assign luma    = luma_reg;
    assign red_q   = red_reg;
    assign green_q = green_reg;
    assign blue_q  = blue_reg;

endmodule

### hdl/lwcb_chan.sv
// Stages 2..4 for one color channel: weight products, sum, floor /255 with saturation.
module lwcb_chan
(
    input  logic                 clk,
    input  lwcb_pkg::stage_ctl_t ctl,
    input  lwcb_pkg::pix_t       luma,
    input  lwcb_pkg::pix_t       comp,
    input  lwcb_pkg::ofs_t       shadow,
    input  lwcb_pkg::ofs_t       highlight,
    output lwcb_pkg::pix_t       result
);

    lwcb_pkg::pix_t     dark;
    logic signed [17:0] p_sh_reg, p_sh_next;
    logic signed [17:0] p_hi_reg, p_hi_next;
    logic [16:0]        c255_reg, c255_next;
    logic signed [18:0] t_reg, t_next;
    logic [15:0]        x;
    logic [15:0]        xq;
    lwcb_pkg::pix_t     res_reg, res_next;

    // stage 2: products
    assign dark      = 8'(8'd255 - luma);
    assign p_sh_next = 18'(shadow * $signed({1'b0, dark}));
    assign p_hi_next = 18'(highlight * $signed({1'b0, luma}));
    assign c255_next = {1'b0, comp, 8'd0} - 17'(comp);

    // stage 3: t = 255*c + weighted offsets, within -65280..130050
    assign t_next = 19'(p_sh_reg) + 19'(p_hi_reg) + 19'($signed({2'b00, c255_reg}));

    // stage 4: floor(t/255) for 0 <= t < 65280 is (x + 1 + (x >> 8)) >> 8
    assign x  = t_reg[15:0];
    assign xq = x + 16'd1 + 16'(x[15:8]);

    always_comb
    begin
        if (t_reg < 0)
            res_next = '0;
        else if (t_reg >= 19'sd65280)
            res_next = 8'd255;
        else
            res_next = xq[15:8];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            p_sh_reg <= p_sh_next;
            p_hi_reg <= p_hi_next;
            c255_reg <= c255_next;
            t_reg    <= t_next;
            res_reg  <= res_next;
        end
    end

    assign result = res_reg;

endmodule

### hdl/luma_weighted_color_balance_core.sv
// Luma-weighted color balance. Each request is one RGBA pixel; the block forms
// an 8-bit luma (77R+150G+29B+128)>>8 and moves each color channel by
// floor((shadow*(255-luma) + highlight*luma)/255), saturating to 0..255.
// Alpha is passed through. The datapath is a four-stage pipeline (luma,
// weight products, sum, divide-by-255 and saturate) that takes one pixel per
// clock whenever the pipe advances. The whole pipe stalls together while
// out_valid is high and out_ready is low; bubbles are not squeezed out, they
// move along with the pipe. The six offsets are written through
// cfg_we/cfg_index/cfg_data (index order: shadow red, green, blue, highlight
// red, green, blue; 9-bit two's complement, reset 0); writes to other indexes
// are dropped. Change offsets only while the pipe is empty.
module luma_weighted_color_balance_core
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_we,
    input  logic [lwcb_pkg::IDX_W-1:0]   cfg_index,
    input  logic [lwcb_pkg::OFS_W-1:0]   cfg_data,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   in_red,
    input  logic [7:0]                   in_green,
    input  logic [7:0]                   in_blue,
    input  logic [7:0]                   in_alpha,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   out_red,
    output logic [7:0]                   out_green,
    output logic [7:0]                   out_blue,
    output logic [7:0]                   out_alpha
);

    // offset registers
    lwcb_pkg::ofs_t sh_r_reg, sh_g_reg, sh_b_reg;
    lwcb_pkg::ofs_t hi_r_reg, hi_g_reg, hi_b_reg;

    // per-stage valid, stage 1 at bit 0
    logic [lwcb_pkg::PIPE_DEPTH-1:0] vld_reg, vld_next;
    logic                            advance;
    lwcb_pkg::stage_ctl_t            ctl;

    // alpha delay line alongside the datapath
    lwcb_pkg::pix_t alpha_reg [lwcb_pkg::PIPE_DEPTH];

    lwcb_pkg::pix_t luma, red_s1, green_s1, blue_s1;

    // -------------------------------------------------------------------
    // Configuration writes
    // -------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh_r_reg <= '0;
            sh_g_reg <= '0;
            sh_b_reg <= '0;
            hi_r_reg <= '0;
            hi_g_reg <= '0;
            hi_b_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lwcb_pkg::CFG_SHADOW_RED:      sh_r_reg <= cfg_data;
                lwcb_pkg::CFG_SHADOW_GREEN:    sh_g_reg <= cfg_data;
                lwcb_pkg::CFG_SHADOW_BLUE:     sh_b_reg <= cfg_data;
                lwcb_pkg::CFG_HIGHLIGHT_RED:   hi_r_reg <= cfg_data;
                lwcb_pkg::CFG_HIGHLIGHT_GREEN: hi_g_reg <= cfg_data;
                lwcb_pkg::CFG_HIGHLIGHT_BLUE:  hi_b_reg <= cfg_data;
                default:                       ; // unmapped index, write dropped
            endcase
        end
    end

    // -------------------------------------------------------------------
    // Pipeline control: whole pipe moves when the output slot is free
    // -------------------------------------------------------------------
    assign advance      = !vld_reg[lwcb_pkg::PIPE_DEPTH-1] || out_ready;
    assign in_ready     = advance;
    assign ctl.advance  = advance;

    assign vld_next = {vld_reg[lwcb_pkg::PIPE_DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            alpha_reg[0] <= in_alpha;
            for (int i = 1; i < lwcb_pkg::PIPE_DEPTH; i++)
                alpha_reg[i] <= alpha_reg[i-1];
        end
    end

    // -------------------------------------------------------------------
    // Datapath
    // -------------------------------------------------------------------
    lwcb_luma u_luma
    (
        .clk     (clk),
        .ctl     (ctl),
        .red     (in_red),
        .green   (in_green),
        .blue    (in_blue),
        .luma    (luma),
        .red_q   (red_s1),
        .green_q (green_s1),
        .blue_q  (blue_s1)
    );

    lwcb_chan u_chan_red
    (
        .clk       (clk),
        .ctl       (ctl),
        .luma      (luma),
        .comp      (red_s1),
        .shadow    (sh_r_reg),
        .highlight (hi_r_reg),
        .result    (out_red)
    );

    lwcb_chan u_chan_green
    (
        .clk       (clk),
        .ctl       (ctl),
        .luma      (luma),
        .comp      (green_s1),
        .shadow    (sh_g_reg),
        .highlight (hi_g_reg),
        .result    (out_green)
    );

    lwcb_chan u_chan_blue
    (
        .clk       (clk),
        .ctl       (ctl),
        .luma      (luma),
        .comp      (blue_s1),
        .shadow    (sh_b_reg),
        .highlight (hi_b_reg),
        .result    (out_blue)
    );

    assign out_valid = vld_reg[lwcb_pkg::PIPE_DEPTH-1];
    assign out_alpha = alpha_reg[lwcb_pkg::PIPE_DEPTH-1];

    // -------------------------------------------------------------------
    // Assertions
    // -------------------------------------------------------------------
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not track output slot");

    a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> $stable(vld_reg))
        else $error("pipeline valids moved during stall");

    // accepted request plus three more advances puts it in the output slot
    a_request_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 in_ready ##1 in_ready ##1 in_ready
        |=> out_valid)
        else $error("accepted request did not reach output after four stages");

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

// Testbench for luma_weighted_color_balance_core.
//
// A queue of pending pixel requests is filled by the main sequence. A clocked
// driver presents them on the input channel with random gaps. At each accepted
// request it computes the balanced pixel and appends it to the queue of
// balanced pixels still due. A clocked monitor stalls the output channel at
// random and compares each accepted result, field by field, with the oldest
// pixel still due.
//
// The offsets are rewritten only when the pipe is empty: after reset, and
// between phases once every due pixel has come back. Directed phases cover
// identity, both saturation rails, the most negative offset -256 and ignored
// writes to unused indexes. Random phases follow with random offsets.
module testbench;

    // Unused register indexes; writes there must be dropped
    localparam logic [lwcb_pkg::IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [lwcb_pkg::IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_PIXELS  = 250;
    // Worst correct run is near 1800 requests, each with the longest gap, the
    // longest stall and the pipe; the limit is a few times that
    localparam int CYCLE_LIMIT   = 900000;

    typedef struct packed {
        lwcb_pkg::pix_t red;
        lwcb_pkg::pix_t green;
        lwcb_pkg::pix_t blue;
        lwcb_pkg::pix_t alpha;
    } pixel_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;

    logic                        cfg_we = 1'b0;
    logic [lwcb_pkg::IDX_W-1:0]  cfg_index = '0;
    logic [lwcb_pkg::OFS_W-1:0]  cfg_data = '0;

    logic           in_valid = 1'b0;
    logic           in_ready;
    lwcb_pkg::pix_t in_red = '0;
    lwcb_pkg::pix_t in_green = '0;
    lwcb_pkg::pix_t in_blue = '0;
    lwcb_pkg::pix_t in_alpha = '0;

    logic           out_valid;
    logic           out_ready = 1'b0;
    lwcb_pkg::pix_t out_red;
    lwcb_pkg::pix_t out_green;
    lwcb_pkg::pix_t out_blue;
    lwcb_pkg::pix_t out_alpha;

    luma_weighted_color_balance_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_red    (in_red),
        .in_green  (in_green),
        .in_blue   (in_blue),
        .in_alpha  (in_alpha),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_alpha (out_alpha)
    );

    // Local copy of the six offsets, kept in step with every write
    lwcb_pkg::ofs_t offsets [lwcb_pkg::NUM_CFG] = '{default: '0};

    pixel_t pending_pixels [$];
    pixel_t balanced_due [$];
    pixel_t on_bus;

    int     pixels_queued = 0;
    int     pixels_checked = 0;
    int     error_count = 0;
    int     cycle_count = 0;
    int     in_gap = 0;
    int     out_hold = 0;
    bit     in_burst = 1'b0;
    bit     out_burst = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    // c + floor((sh*(255-luma) + hi*luma)/255), clamped to 0..255
    function automatic lwcb_pkg::pix_t shift_channel(lwcb_pkg::pix_t c, int luma,
                                                     lwcb_pkg::ofs_t sh,
                                                     lwcb_pkg::ofs_t hi);
        int acc;
        int q;
        acc = int'(c) * 255 + int'(sh) * (255 - luma) + int'(hi) * luma;
        q = acc / 255;
        // division truncates toward zero; pull negatives down to the floor
        if (acc < 0 && (acc % 255) != 0)
            q = q - 1;
        if (q < 0)
            q = 0;
        if (q > 255)
            q = 255;
        return lwcb_pkg::pix_t'(q);
    endfunction

    function automatic pixel_t balance_pixel(pixel_t px);
        pixel_t res;
        int     luma;
        luma = (int'(lwcb_pkg::LUMA_WR) * int'(px.red)
                + int'(lwcb_pkg::LUMA_WG) * int'(px.green)
                + int'(lwcb_pkg::LUMA_WB) * int'(px.blue)
                + int'(lwcb_pkg::LUMA_RND)) >>> 8;
        res.red   = shift_channel(px.red, luma, offsets[lwcb_pkg::CFG_SHADOW_RED],
                                  offsets[lwcb_pkg::CFG_HIGHLIGHT_RED]);
        res.green = shift_channel(px.green, luma, offsets[lwcb_pkg::CFG_SHADOW_GREEN],
                                  offsets[lwcb_pkg::CFG_HIGHLIGHT_GREEN]);
        res.blue  = shift_channel(px.blue, luma, offsets[lwcb_pkg::CFG_SHADOW_BLUE],
                                  offsets[lwcb_pkg::CFG_HIGHLIGHT_BLUE]);
        res.alpha = px.alpha;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Random helpers
    // ---------------------------------------------------------------

    // Mostly short gaps, a few long ones; none at all in burst phases
    function automatic int pick_gap(bit burst);
        int roll;
        roll = $urandom_range(0, 99);
        if (burst || roll < 60)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Rails show up often so that saturation gets hit
    function automatic lwcb_pkg::pix_t pick_component();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        else if (roll == 1)
            return '1;
        else
            return lwcb_pkg::pix_t'($urandom_range(0, 255));
    endfunction

    function automatic int pick_offset();
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0)
            return -256;
        else if (roll == 1)
            return 255;
        else if (roll == 2)
            return -255;
        else if (roll == 3)
            return int'($urandom_range(0, 16)) - 8;
        else
            return int'(lwcb_pkg::ofs_t'($urandom_range(0, 511)));
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        $display("[%0t] mismatch: %s got %0d want %0d", $realtime, what, got, want);
    endtask

    // ---------------------------------------------------------------
    // Configuration and sequencing
    // ---------------------------------------------------------------

    task automatic write_offset(logic [lwcb_pkg::IDX_W-1:0] idx, int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= lwcb_pkg::OFS_W'(value);
        if (idx < lwcb_pkg::NUM_CFG)
            offsets[idx] = lwcb_pkg::ofs_t'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic write_all(int sr, int sg, int sb, int hr, int hg, int hb);
        write_offset(lwcb_pkg::CFG_SHADOW_RED, sr);
        write_offset(lwcb_pkg::CFG_SHADOW_GREEN, sg);
        write_offset(lwcb_pkg::CFG_SHADOW_BLUE, sb);
        write_offset(lwcb_pkg::CFG_HIGHLIGHT_RED, hr);
        write_offset(lwcb_pkg::CFG_HIGHLIGHT_GREEN, hg);
        write_offset(lwcb_pkg::CFG_HIGHLIGHT_BLUE, hb);
    endtask

    task automatic queue_rgba(int r, int g, int b, int a);
        pixel_t px;
        px.red   = lwcb_pkg::pix_t'(r);
        px.green = lwcb_pkg::pix_t'(g);
        px.blue  = lwcb_pkg::pix_t'(b);
        px.alpha = lwcb_pkg::pix_t'(a);
        pending_pixels = {pending_pixels, px};
        pixels_queued++;
    endtask

    // Every request returns one pixel, so matching counts means the pipe is
    // empty; the task still waits past the pipe depth anyway
    task automatic wait_drained();
        while (pixels_checked != pixels_queued)
            @(posedge clk);
        repeat (lwcb_pkg::PIPE_DEPTH + 4) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Input driver: one request in flight, held until accepted
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                balanced_due = {balanced_due, balance_pixel(on_bus)};
            // slot is free if nothing was on the bus or it just went in
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_pixels.size() > 0)
                begin
                    on_bus = pending_pixels.pop_front();
                    in_red   <= on_bus.red;
                    in_green <= on_bus.green;
                    in_blue  <= on_bus.blue;
                    in_alpha <= on_bus.alpha;
                    in_valid <= 1'b1;
                    in_gap = pick_gap(in_burst);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Output monitor: random back-pressure, in-order compare
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (balanced_due.size() == 0)
                    report_mismatch("result with nothing due, red", out_red, 0);
                else
                begin
                    want = balanced_due.pop_front();
                    pixels_checked++;
                    if (out_red !== want.red)
                        report_mismatch("out_red", out_red, want.red);
                    if (out_green !== want.green)
                        report_mismatch("out_green", out_green, want.green);
                    if (out_blue !== want.blue)
                        report_mismatch("out_blue", out_blue, want.blue);
                    if (out_alpha !== want.alpha)
                        report_mismatch("out_alpha", out_alpha, want.alpha);
                end
            end
            if (out_hold == 0)
                out_hold = pick_gap(out_burst);
            else
                out_hold--;
            out_ready <= (out_hold == 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Offsets at reset value: every pixel must come back unchanged
        queue_rgba(0, 0, 0, 0);
        queue_rgba(255, 255, 255, 255);
        queue_rgba(255, 0, 0, 170);
        queue_rgba(0, 255, 0, 85);
        queue_rgba(0, 0, 255, 1);
        queue_rgba(128, 64, 32, 254);
        wait_drained();

        // Full positive offsets: every pixel pins at 255
        write_all(255, 255, 255, 255, 255, 255);
        queue_rgba(0, 0, 0, 17);
        queue_rgba(255, 255, 255, 34);
        queue_rgba(200, 10, 90, 51);
        queue_rgba(1, 1, 1, 68);
        wait_drained();

        // Pattern -256 everywhere: everything pins at 0
        write_all(-256, -256, -256, -256, -256, -256);
        queue_rgba(255, 255, 255, 0);
        queue_rgba(0, 0, 0, 255);
        queue_rgba(255, 128, 0, 128);
        queue_rgba(12, 240, 77, 200);
        wait_drained();

        // Opposite signs for shadow and highlight; writes to unused indexes
        // must leave the offsets alone
        write_all(-255, 100, 255, 255, -100, -255);
        write_offset(CFG_SPARE_6, 255);
        write_offset(CFG_SPARE_7, -256);
        queue_rgba(0, 0, 0, 3);
        queue_rgba(255, 255, 255, 12);
        queue_rgba(127, 128, 129, 48);
        queue_rgba(0, 255, 255, 192);
        queue_rgba(255, 0, 255, 96);
        queue_rgba(60, 30, 250, 24);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            for (int r = 0; r < lwcb_pkg::NUM_CFG; r++)
                if (ph == 0 || $urandom_range(0, 3) != 0)
                    write_offset(r[lwcb_pkg::IDX_W-1:0], pick_offset());
            if ($urandom_range(0, 2) == 0)
                write_offset($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7,
                             int'(lwcb_pkg::ofs_t'($urandom_range(0, 511))));
            in_burst  = ($urandom_range(0, 3) == 0);
            out_burst = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_PIXELS; n++)
                queue_rgba(pick_component(), pick_component(), pick_component(),
                           $urandom_range(0, 255));
            wait_drained();
        end

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
